### hw/rtl/tphf_pkg.sv
// shared types, constants and helpers for the topic port hash fold unit
package tphf_pkg;

  // fnv-1a 64-bit constants
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam int unsigned FNV_PRIME_HI_SHIFT = 40;      // prime = 2^40 + 0x1b3
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;

  // topic span used to reduce the hash
  localparam int unsigned TOPIC_SPAN = 10000;
  localparam int unsigned SPAN_W = 14;                  // holds 0 .. TOPIC_SPAN-1

  // residues of 2^16, 2^32 and 2^48 modulo the topic span
  localparam logic [SPAN_W-1:0] SPAN_R16 = 14'd5536;
  localparam logic [SPAN_W-1:0] SPAN_R32 = 14'd7296;
  localparam logic [SPAN_W-1:0] SPAN_R48 = 14'd656;

  // folded hash width, quotient width and reciprocal of the span
  // span = 625 << 4; quotient = ((v >> 4) * ceil(2^36 / 625)) >> 36
  localparam int unsigned FOLD_W       = 30;
  localparam int unsigned QUO_W        = 17;
  localparam int unsigned SPAN_TZ      = 4;
  localparam int unsigned RECIP_W      = 27;
  localparam int unsigned RECIP_SHIFT  = 36;
  localparam int unsigned RECIP_PROD_W = FOLD_W - SPAN_TZ + RECIP_W;
  localparam logic [RECIP_W-1:0] SPAN_RECIP = 27'd109951163;

  // field and register widths
  localparam int unsigned HASH_W = 64;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned DOM_W  = 31;
  localparam int unsigned PROD_W = DOM_W + SPAN_W;      // domain * reduced hash
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PORT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_ID   = 2'd2;

  // register reset values
  localparam logic [PORT_W-1:0] BASE_PORT_RST   = 16'd0;
  localparam logic [PORT_W-1:0] PORT_WINDOW_RST = 16'd10000;
  localparam logic [DOM_W-1:0]  DOMAIN_ID_RST   = 31'd0;

  // steps of the span reduction, counted down
  localparam logic [CNT_W-1:0] REM_FOLD_STEP = CNT_W'(2);
  localparam logic [CNT_W-1:0] REM_QUO_STEP  = CNT_W'(1);
  localparam logic [CNT_W-1:0] REM_SUB_STEP  = CNT_W'(0);

  // top product bit, where the counter of the serial window fold starts
  localparam logic [CNT_W-1:0] FOLD_LAST_BIT = CNT_W'(PROD_W - 1);

  typedef struct packed {
    logic [7:0] name_byte;
    logic       byte_valid;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [HASH_W-1:0] name_hash;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic hash_en;     // input transaction taken
    logic rem_start;   // capture hash, arm the span reduction
    logic rem_step;    // one step of the span reduction
    logic mul_en;      // domain product, arm the window fold
    logic fold_step;   // one bit of the window fold
    logic load_out;    // write the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_zero;
  } sts_t;

  // one fnv-1a round: xor the byte in, multiply by the prime mod 2^64
  function automatic logic [HASH_W-1:0] fnv_round(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << FNV_PRIME_HI_SHIFT) + (x * {55'd0, FNV_PRIME_LO});
  endfunction

endpackage

### hw/rtl/tphf_ctrl.sv
// controller state machine for the topic port hash fold unit
module tphf_ctrl
  import tphf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REM  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_take;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_take  = out_valid_r & out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_take;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.hash_en = 1'b1;
          if (in_last) begin
            cmd.rem_start = 1'b1;
            state_nxt     = S_REM;
          end
        end
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (sts.cnt_zero) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold_step = 1'b1;
        if (sts.cnt_zero) state_nxt = S_DONE;
      end
      S_DONE: begin
        // result register free or emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");

  // a last transaction always starts the span reduction
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> (state_r == S_REM))
    else $error("last transaction did not start reduction");

  // fold ends in the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD && sts.cnt_zero) |=> (state_r == S_DONE))
    else $error("fold did not finish into done");

endmodule

### hw/rtl/tphf_dp.sv
// datapath: running hash, config registers, span reduction and serial window fold
module tphf_dp
  import tphf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_t                   in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output out_t                  out_data
);

  logic [PORT_W-1:0]       base_r, win_r;
  logic [DOM_W-1:0]        dom_r;
  logic [HASH_W-1:0]       run_r, run_nxt;
  logic [HASH_W-1:0]       cap_r, cap_nxt;
  logic [HASH_W-1:0]       hash_upd;
  logic [SPAN_W-1:0]       r_r, r_nxt;
  logic [FOLD_W-1:0]       fold_r, fold_nxt;
  logic [FOLD_W-1:0]       fold_sum;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [FOLD_W-1:0]       span_rem;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [PORT_W-1:0]       rem_r, rem_nxt;
  logic [PORT_W:0]         rem_sh;
  logic [PORT_W-1:0]       offset;
  out_t                    out_r, out_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_PORT_RST;
      win_r  <= PORT_WINDOW_RST;
      dom_r  <= DOMAIN_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_PORT:   base_r <= cfg_data[PORT_W-1:0];
        REG_PORT_WINDOW: win_r  <= cfg_data[PORT_W-1:0];
        REG_DOMAIN_ID:   dom_r  <= cfg_data[DOM_W-1:0];
        default: ;
      endcase
    end
  end

  // running hash, captured and rewound on the last transaction
  assign hash_upd = in_data.byte_valid ? fnv_round(run_r, in_data.name_byte) : run_r;

  always_comb begin
    run_nxt = run_r;
    cap_nxt = cap_r;
    if (cmd.hash_en) begin
      if (in_data.last) begin
        cap_nxt = hash_upd;
        run_nxt = FNV_BASIS;
      end else begin
        run_nxt = hash_upd;
      end
    end
  end

  // span reduction: fold 16-bit chunks by their residues, then reciprocal quotient and subtraction
  assign fold_sum = FOLD_W'(cap_r[15:0]) +
                    FOLD_W'(cap_r[31:16]) * FOLD_W'(SPAN_R16) +
                    FOLD_W'(cap_r[47:32]) * FOLD_W'(SPAN_R32) +
                    FOLD_W'(cap_r[63:48]) * FOLD_W'(SPAN_R48);

  assign recip_prod = RECIP_PROD_W'(fold_r[FOLD_W-1:SPAN_TZ]) * RECIP_PROD_W'(SPAN_RECIP);

  assign span_rem = fold_r - FOLD_W'(quo_r) * FOLD_W'(TOPIC_SPAN);

  // window fold, one product bit per cycle from the top
  assign rem_sh = {rem_r, prod_r[cnt_r]};

  always_comb begin
    r_nxt    = r_r;
    fold_nxt = fold_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    if (cmd.rem_start) begin
      cnt_nxt = REM_FOLD_STEP;
    end else if (cmd.rem_step) begin
      case (cnt_r)
        REM_FOLD_STEP: fold_nxt = fold_sum;
        REM_QUO_STEP:  quo_nxt  = recip_prod[RECIP_SHIFT +: QUO_W];
        REM_SUB_STEP:  r_nxt    = span_rem[SPAN_W-1:0];
        default: ;
      endcase
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd.mul_en) begin
      prod_nxt = PROD_W'(dom_r) * PROD_W'(r_r);
      rem_nxt  = '0;
      cnt_nxt  = FOLD_LAST_BIT;
    end else if (cmd.fold_step) begin
      if (rem_sh >= {1'b0, win_r}) rem_nxt = PORT_W'(rem_sh - {1'b0, win_r});
      else                         rem_nxt = rem_sh[PORT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);

  // zero window passes the offset through unfolded
  assign offset = (win_r == '0) ? prod_r[PORT_W-1:0] : rem_r;

  always_comb begin
    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt.port      = base_r + offset;
      out_nxt.name_hash = cap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= FNV_BASIS;
      r_r   <= '0;
      rem_r <= '0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      r_r   <= r_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r  <= cap_nxt;
    fold_r <= fold_nxt;
    quo_r  <= quo_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

  // span remainder stays reduced
  assert property (@(posedge clk) disable iff (!rst_n)
    r_r < SPAN_W'(TOPIC_SPAN))
    else $error("span remainder out of range");

  // fold remainder stays below a nonzero window
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.fold_step) && (win_r != '0) |-> (rem_r < win_r))
    else $error("fold remainder not below window");

endmodule

### hw/rtl/topic_port_hash_fold_unit.sv
// top level of the topic port hash fold unit
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-----------------------------
//  in      | in_valid, in_ready, in_data    | input     | name_byte, byte_valid, last
//  out     | out_valid, out_ready, out_data | output    | port, name_hash
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | input | register index, data
//
//  a transaction without last leaves the unit idle and ready; the hash round is combinational
//  a last transaction holds off the next input until the unit has accepted it, run the
//  span reduction (fold, quotient, subtract), formed the domain product, run the
//  bit-serial fold and loaded the result register
//  the result register lets a finished result wait while the next name streams in;
//  a second finished result waits in the done state until the first is taken
//  synchronous active-low reset; the running hash resets to the offset basis
module topic_port_hash_fold_unit
  import tphf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tphf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tphf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

### tb/port_hash_checker.sv
`timescale 1ns / 100ps
// checker for the topic port hash fold unit: predicts every port and name hash and compares
module port_hash_checker
  import tphf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    err_count,
  output int                    pending
);

  // fnv-1a 64-bit start value and multiplier
  localparam logic [HASH_W-1:0] OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HASH_W-1:0] HASH_PRIME   = 64'h0000_0100_0000_01B3;

  // shadow of the running hash and the registers
  logic [HASH_W-1:0] topic_hash;
  logic [PORT_W-1:0] base_port;
  logic [PORT_W-1:0] port_window;
  logic [DOM_W-1:0]  dom_mult;

  // results still owed by the block, oldest first
  out_t expected_ports[$];

  task automatic report_mismatch(input string what);
    $display("checker: mismatch at %0t ns: %s", $time, what);
    err_count++;
  endtask

  // reduce the hash, scale by the domain, fold into the window, add the base
  function automatic logic [PORT_W-1:0] derive_port(input logic [HASH_W-1:0] h);
    logic [63:0] offset;
    offset = 64'(dom_mult) * (h % 64'(TOPIC_SPAN));
    // a zero window leaves the offset unfolded
    if (port_window != '0 && offset >= 64'(port_window))
      offset = offset % 64'(port_window);
    return base_port + offset[PORT_W-1:0];
  endfunction

  always @(posedge clk) begin
    out_t seen;
    out_t want;
    if (!rst_n) begin
      topic_hash  = OFFSET_BASIS;
      base_port   = 16'd0;
      port_window = 16'd10000;
      dom_mult    = '0;
      err_count   = 0;
      expected_ports.delete();
    end else begin
      // register write; the spare index changes nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_PORT:   base_port   = cfg_data[PORT_W-1:0];
          REG_PORT_WINDOW: port_window = cfg_data[PORT_W-1:0];
          REG_DOMAIN_ID:   dom_mult    = cfg_data[DOM_W-1:0];
          default: ;
        endcase
      end

      // name byte transaction: hash valid bytes, close the name on last
      if (in_valid && in_ready) begin
        if (in_data.byte_valid)
          topic_hash = (topic_hash ^ {56'd0, in_data.name_byte}) * HASH_PRIME;
        if (in_data.last) begin
          want.port      = derive_port(topic_hash);
          want.name_hash = topic_hash;
          expected_ports.push_back(want);
          topic_hash = OFFSET_BASIS;
        end
      end

      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        seen = out_data;
        if (expected_ports.size() == 0) begin
          report_mismatch($sformatf("result with none owed: port %0d hash %h",
                                    seen.port, seen.name_hash));
        end else begin
          want = expected_ports.pop_front();
          if (seen.port !== want.port)
            report_mismatch($sformatf("port %0d, predicted %0d (hash %h)",
                                      seen.port, want.port, want.name_hash));
          if (seen.name_hash !== want.name_hash)
            report_mismatch($sformatf("name hash %h, predicted %h",
                                      seen.name_hash, want.name_hash));
        end
      end
    end
    pending <= expected_ports.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench top for the topic port hash fold unit: clock, reset, stimulus and verdict
module testbench;
  import tphf_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 130;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 5;
  localparam int PHASE_ITEMS    = 108;
  localparam int PRESSURE_PHASE = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
  localparam logic [PORT_W-1:0]    PORT_MAX   = 16'hFFFF;
  localparam logic [DOM_W-1:0]     DOMAIN_MAX = 31'h7FFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int err_count;
  int pending;

  // stimulus mode
  logic hold_req = 1'b0;
  logic calm     = 1'b0;
  bit   idle_en  = 1'b1;
  int   phase_items;

  // receiver state
  int   rx_gap;
  int   rx_steady;
  int   hold_left;
  logic hold_taken;
  int   idle_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  topic_port_hash_fold_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  port_hash_checker hash_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  // offer one name byte transaction, maybe after a short gap, and wait for it to be taken
  task automatic send_item(input logic [7:0] b, input logic v, input logic l);
    in_t it;
    int  gap;
    it.name_byte  = b;
    it.byte_valid = v;
    it.last       = l;
    if (idle_en && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (v || l) phase_items++;
  endtask

  // one register write; the caller drops valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all three registers plus the unmapped index; fill sets the bits above each field
  task automatic set_config(input logic [PORT_W-1:0] base, input logic [PORT_W-1:0] window,
                            input logic [DOM_W-1:0] domain, input logic [CFG_DATA_W-1:0] fill);
    write_reg(REG_BASE_PORT, {fill[31:16], base});
    write_reg(REG_PORT_WINDOW, {fill[31:16], window});
    write_reg(REG_DOMAIN_ID, {fill[31], domain});
    write_reg(REG_SPARE, fill);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every owed result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, steady stretches, one long hold-off, none at the end
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      rx_gap     <= 0;
      rx_steady  <= 0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES - 1;
      hold_taken <= 1'b1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else if (rx_steady != 0) begin
      out_ready <= 1'b1;
      rx_steady <= rx_steady - 1;
    end else begin
      case ($urandom_range(0, 7))
        0, 1: begin
          out_ready <= 1'b0;
          rx_gap    <= $urandom_range(0, 4);
        end
        2: begin
          out_ready <= 1'b1;
          rx_steady <= $urandom_range(20, 60);
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [PORT_W-1:0] base;
    logic [PORT_W-1:0] window;
    logic [DOM_W-1:0]  domain;
    int                len;
    bit                marker_end;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty name, bytes at both extremes, an ignored byte mid-name
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    settle();

    // every register at its top, stray upper bits; the port sum wraps
    set_config(PORT_MAX, PORT_MAX, DOMAIN_MAX, '1);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h42, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    settle();

    // zero window passes the offset through; a name closed by a byteless last
    set_config(16'd100, 16'd0, 31'd7, '0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b1);
    send_item(8'h10, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);
    send_item(8'h7F, 1'b1, 1'b1);
    settle();

    // window of one folds every offset to zero
    set_config(16'd0, 16'd1, DOMAIN_MAX, $urandom);
    send_item(8'h01, 1'b1, 1'b1);
    settle();

    // random phases, each under new settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = PORT_MAX;
        default: base = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: window = '0;
        1: window = 16'd1;
        2: window = PORT_MAX;
        3: window = 16'($urandom_range(2, 300));
        default: window = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 4))
        0: domain = '0;
        1: domain = DOMAIN_MAX;
        2: domain = 31'($urandom_range(1, 300));
        default: domain = 31'($urandom);
      endcase
      set_config(base, window, domain, $urandom);

      // long hold-off on the result side while names keep coming
      if (p == PRESSURE_PHASE) hold_req <= 1'b1;
      if (p == RAND_PHASES - 1) calm <= 1'b1;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // mostly short names, a few long ones and some empty ones
        len = ($urandom_range(0, 15) == 0) ? 0 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        marker_end = (len == 0) || ($urandom_range(0, 5) == 0);
        idle_en = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
          send_item(8'($urandom), 1'b1, (k == len - 1) && !marker_end);
        end
        if (marker_end) send_item(8'($urandom), 1'b0, 1'b1);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
